FILE: rtl/csq_pkg.sv
// Shared types, widths and register codes of the chi-square class statistic unit.
package csq_pkg;

	localparam int CNT_W    = 20;
	localparam int FRAC_W   = 16;
	localparam int MAX_CLS  = 4;
	localparam int STAT_W   = 40;
	localparam int USED_W   = 3;
	localparam int ADDR_W   = 5;
	localparam int CFG_DW   = 32;
	localparam int PB_W     = 2 * CNT_W;
	localparam int E_W      = 2 * CNT_W + 1;
	localparam int EL_W     = (E_W + 1) / 2;
	localparam int EH_W     = E_W - EL_W;
	localparam int SQ_W     = 2 * E_W;
	localparam int NUM_W    = SQ_W + FRAC_W - 2;
	localparam int DEN_W    = 3 * CNT_W;
	localparam int Q_W      = STAT_W + 10;
	localparam int SUM_W    = Q_W + 3;
	localparam int DIV_CONST = 1000;
	localparam int RCP_PRE  = 3;
	localparam int SCL_W    = Q_W - RCP_PRE;
	localparam int HALF_W   = 24;
	localparam int RCP_W    = 2 * HALF_W;
	localparam int PRD_W    = SCL_W + RCP_W;
	localparam int RCP_SH   = 54;
	localparam logic [RCP_W-1:0] RCP_M = 48'd144115188075856;

	typedef enum logic [2:0] {
		REG_TOTAL,
		REG_CLS0,
		REG_CLS1,
		REG_CLS2,
		REG_CLS3,
		REG_USED
	} reg_idx_t;

	typedef struct packed {
		logic [CNT_W-1:0]               total_count;
		logic [MAX_CLS-1:0][CNT_W-1:0]  class_total;
		logic [USED_W-1:0]              classes_used;
	} cfg_t;

	typedef struct packed {
		logic [CNT_W-1:0] occurrences;
		logic [CNT_W-1:0] observed_0;
		logic [CNT_W-1:0] observed_1;
		logic [CNT_W-1:0] observed_2;
		logic [CNT_W-1:0] observed_3;
	} in_item_t;

	typedef struct packed {
		logic [STAT_W-1:0] statistic;
		logic              integrity_error;
	} out_item_t;

	typedef struct packed {
		logic [CNT_W-1:0]              x;
		logic [MAX_CLS-1:0][CNT_W-1:0] obs;
		logic [MAX_CLS-1:0]            en;
		logic                          err;
	} fe_rec_t;

	typedef struct packed {
		logic err;
		logic sat;
	} div_tag_t;

	typedef struct packed {
		logic             valid;
		div_tag_t         tag;
		logic [NUM_W-1:0] num;
		logic [DEN_W-1:0] den;
	} div_in_t;

	typedef struct packed {
		logic           valid;
		div_tag_t       tag;
		logic           ovf;
		logic [Q_W-1:0] quo;
	} div_out_t;

endpackage

FILE: rtl/chi_square_class_statistic_unit.sv
// Top level of the chi-square class statistic unit: register port, front end, queue, back end.
// The unit takes one item per clock and busy never rises, since the back end drains the queue
// every cycle. Each result appears with done for one cycle; on its way it passes the front
// register, the queue, the per-class product stages and the bit-per-stage divider of the
// per-class terms, with a short reciprocal multiply for the scaling by 1000 behind it.
// Results come in acceptance order and cannot be held off.
module chi_square_class_statistic_unit import csq_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  in_item_t          item,
	output logic              done,
	output out_item_t         result,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [CFG_DW-1:0] pwdata,
	output logic [CFG_DW-1:0] prdata,
	output logic              pready
);

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;
	logic     fe_valid;
	fe_rec_t  fe_rec;
	logic     q_full;
	logic     q_valid;
	fe_rec_t  q_head;

	assign pready = 1'b1;
	assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.total_count  <= CNT_W'(1);
			cfg_q.class_total  <= '0;
			cfg_q.classes_used <= USED_W'(2);
		end else if (wr_en) begin
			unique case (idx)
				REG_TOTAL: cfg_q.total_count    <= pwdata[CNT_W-1:0];
				REG_CLS0:  cfg_q.class_total[0] <= pwdata[CNT_W-1:0];
				REG_CLS1:  cfg_q.class_total[1] <= pwdata[CNT_W-1:0];
				REG_CLS2:  cfg_q.class_total[2] <= pwdata[CNT_W-1:0];
				REG_CLS3:  cfg_q.class_total[3] <= pwdata[CNT_W-1:0];
				REG_USED:  cfg_q.classes_used   <= pwdata[USED_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_TOTAL: prdata = CFG_DW'(cfg_q.total_count);
			REG_CLS0:  prdata = CFG_DW'(cfg_q.class_total[0]);
			REG_CLS1:  prdata = CFG_DW'(cfg_q.class_total[1]);
			REG_CLS2:  prdata = CFG_DW'(cfg_q.class_total[2]);
			REG_CLS3:  prdata = CFG_DW'(cfg_q.class_total[3]);
			REG_USED:  prdata = CFG_DW'(cfg_q.classes_used);
			default:   prdata = '0;
		endcase
	end

	csq_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.item      (item),
		.cfg       (cfg_q),
		.full      (q_full),
		.busy      (busy),
		.rec_valid (fe_valid),
		.rec       (fe_rec)
	);

	csq_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (fe_valid),
		.push_rec   (fe_rec),
		.full       (q_full),
		.head_valid (q_valid),
		.head       (q_head)
	);

	csq_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.in_valid (q_valid),
		.rec      (q_head),
		.done     (done),
		.result   (result)
	);

	a_never_full: assert property (@(posedge clk) disable iff (!arst_n) !q_full)
		else $error("queue filled although the back end drains it every cycle");

	a_push_lands: assert property (@(posedge clk) disable iff (!arst_n) fe_valid |=> q_valid)
		else $error("front beat did not reach the queue");

endmodule

FILE: rtl/csq_front.sv
// Front end: accepts an item, clamps the class count, flags slots and checks the observed sum.
module csq_front import csq_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  in_item_t item,
	input  cfg_t     cfg,
	input  logic     full,
	output logic     busy,
	output logic     rec_valid,
	output fe_rec_t  rec
);

	logic [USED_W-1:0]             used;
	logic [MAX_CLS-1:0][CNT_W-1:0] obs;
	logic [CNT_W+1:0]              osum;
	fe_rec_t                       nxt;
	logic                          accept;
	logic                          valid_s1;
	fe_rec_t                       rec_s1;

	assign busy   = valid_s1 && full;
	assign accept = start && !busy;

	always_comb begin
		used = cfg.classes_used;
		if (used == '0) used = USED_W'(1);
		if (used > USED_W'(MAX_CLS)) used = USED_W'(MAX_CLS);
		obs[0] = item.observed_0;
		obs[1] = item.observed_1;
		obs[2] = item.observed_2;
		obs[3] = item.observed_3;
		osum = '0;
		nxt.x = item.occurrences;
		for (int k = 0; k < MAX_CLS; k++) begin
			if (USED_W'(k) < used) begin
				osum = osum + (CNT_W+2)'(obs[k]);
			end
			nxt.obs[k] = obs[k];
			nxt.en[k]  = (USED_W'(k) < used) && (cfg.total_count != '0)
				&& (cfg.class_total[k] != '0) && (item.occurrences != '0);
		end
		nxt.err = osum != (CNT_W+2)'(item.occurrences);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (!full) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rec_s1 <= nxt;
		end
	end

	assign rec_valid = valid_s1;
	assign rec       = rec_s1;

endmodule

FILE: rtl/csq_queue.sv
// Two-entry queue between the front end and the arithmetic back end.
module csq_queue import csq_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  fe_rec_t push_rec,
	output logic    full,
	output logic    head_valid,
	output fe_rec_t head
);

	fe_rec_t    mem [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       do_push;
	logic       do_pop;

	assign full       = cnt_q == 2'd2;
	assign head_valid = cnt_q != 2'd0;
	assign head       = mem[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = head_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (do_push) wr_ptr_q <= !wr_ptr_q;
			if (do_pop) rd_ptr_q <= !rd_ptr_q;
			cnt_q <= cnt_q + 2'(do_push) - 2'(do_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[wr_ptr_q] <= push_rec;
		end
	end

endmodule

FILE: rtl/csq_div.sv
// Pipelined restoring divider, one quotient bit per stage, with overflow detect.
module csq_div import csq_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_in_t  din,
	output div_out_t dout
);

	logic             valid_q [Q_W+1];
	div_tag_t         tag_q   [Q_W+1];
	logic             ovf_q   [Q_W+1];
	logic [NUM_W-1:0] rem_q   [Q_W+1];
	logic [DEN_W-1:0] den_q   [Q_W+1];
	logic [Q_W-1:0]   quo_q   [Q_W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q[0] <= 1'b0;
		end else begin
			valid_q[0] <= din.valid;
		end
	end

	always_ff @(posedge clk) begin
		tag_q[0] <= din.tag;
		ovf_q[0] <= (din.num >> Q_W) >= NUM_W'(din.den);
		rem_q[0] <= din.num;
		den_q[0] <= din.den;
		quo_q[0] <= '0;
	end

	for (genvar j = 1; j <= Q_W; j++) begin : g_st
		localparam int SH = Q_W - j;
		logic [DEN_W:0] top;
		logic           ge;

		assign top = (DEN_W+1)'(rem_q[j-1] >> SH);
		assign ge  = top >= {1'b0, den_q[j-1]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_q[j] <= 1'b0;
			end else begin
				valid_q[j] <= valid_q[j-1];
			end
		end

		always_ff @(posedge clk) begin
			tag_q[j] <= tag_q[j-1];
			ovf_q[j] <= ovf_q[j-1];
			den_q[j] <= den_q[j-1];
			rem_q[j] <= ge ? rem_q[j-1] - (NUM_W'(den_q[j-1]) << SH) : rem_q[j-1];
			quo_q[j] <= quo_q[j-1] | (ge ? (Q_W'(1) << SH) : '0);
		end
	end

	assign dout.valid = valid_q[Q_W];
	assign dout.tag   = tag_q[Q_W];
	assign dout.ovf   = ovf_q[Q_W];
	assign dout.quo   = quo_q[Q_W];

endmodule

FILE: rtl/csq_back.sv
// Back end: per-class products, squared deviation, term division, sum and scaling.
module csq_back import csq_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  cfg_t      cfg,
	input  logic      in_valid,
	input  fe_rec_t   rec,
	output logic      done,
	output out_item_t result
);

	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6, done_q;
	logic err_s1, err_s2, err_s3, err_s4, err_s5, err_s6, sat_s5, sat_s6;
	logic [SUM_W-1:0]    sum_s5;
	logic [SUM_W-1:0]    sum;
	logic [SCL_W-1:0]    scl;
	logic [2*HALF_W-1:0] pp_ll_s6, pp_lh_s6, pp_hl_s6, pp_hh_s6;
	logic [PRD_W-1:0]    prod;
	out_item_t           res_q;
	div_out_t            tdiv [MAX_CLS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= tdiv[0].valid;
			valid_s6 <= valid_s5;
			done_q   <= valid_s6;
		end
	end

	always_ff @(posedge clk) begin
		err_s1 <= rec.err;
		err_s2 <= err_s1;
		err_s3 <= err_s2;
		err_s4 <= err_s3;
	end

	for (genvar k = 0; k < MAX_CLS; k++) begin : g_lane
		logic [PB_W-1:0]       pa_s1, pb_s1, d;
		logic                  en_s1, en_s2, en_s3, en_s4;
		logic [E_W-1:0]        twod, ne, e_s2;
		logic [PB_W-1:0]       pbn_lo_s2, pbn_hi_s2;
		logic [2*EH_W-1:0]     phh_s3;
		logic [EH_W+EL_W-1:0]  phl_s3;
		logic [2*EL_W-1:0]     pll_s3;
		logic [DEN_W-1:0]      den_s3, den_s4;
		logic [SQ_W-1:0]       sq;
		logic [NUM_W-1:0]      num_s4;
		div_in_t               din;

		always_ff @(posedge clk) begin
			pa_s1 <= PB_W'(rec.obs[k]) * PB_W'(cfg.total_count);
			pb_s1 <= PB_W'(cfg.class_total[k]) * PB_W'(rec.x);
			en_s1 <= rec.en[k];
		end

		always_comb begin
			d    = (pa_s1 > pb_s1) ? pa_s1 - pb_s1 : pb_s1 - pa_s1;
			twod = {d, 1'b0};
			ne   = E_W'(cfg.total_count);
		end

		always_ff @(posedge clk) begin
			e_s2      <= (twod >= ne) ? twod - ne : ne - twod;
			pbn_lo_s2 <= PB_W'(pb_s1[CNT_W-1:0]) * PB_W'(cfg.total_count);
			pbn_hi_s2 <= PB_W'(pb_s1[PB_W-1:CNT_W]) * PB_W'(cfg.total_count);
			en_s2     <= en_s1;
		end

		always_ff @(posedge clk) begin
			phh_s3 <= (2*EH_W)'(e_s2[E_W-1:EL_W]) * (2*EH_W)'(e_s2[E_W-1:EL_W]);
			phl_s3 <= (EH_W+EL_W)'(e_s2[E_W-1:EL_W]) * (EH_W+EL_W)'(e_s2[EL_W-1:0]);
			pll_s3 <= (2*EL_W)'(e_s2[EL_W-1:0]) * (2*EL_W)'(e_s2[EL_W-1:0]);
			den_s3 <= (DEN_W'(pbn_hi_s2) << CNT_W) + DEN_W'(pbn_lo_s2);
			en_s3  <= en_s2;
		end

		assign sq = (SQ_W'(phh_s3) << (2*EL_W)) + (SQ_W'(phl_s3) << (EL_W+1))
			+ SQ_W'(pll_s3);

		always_ff @(posedge clk) begin
			num_s4 <= en_s3 ? (NUM_W'(sq) << (FRAC_W-2)) : '0;
			den_s4 <= en_s3 ? den_s3 : DEN_W'(1);
			en_s4  <= en_s3;
		end

		always_comb begin
			din.valid   = valid_s4;
			din.tag.err = err_s4;
			din.tag.sat = !en_s4;
			din.num     = num_s4;
			din.den     = den_s4;
		end

		csq_div u_div (
			.clk    (clk),
			.arst_n (arst_n),
			.din    (din),
			.dout   (tdiv[k])
		);
	end

	always_comb begin
		sum = '0;
		for (int k = 0; k < MAX_CLS; k++) begin
			sum = sum + (tdiv[k].ovf ? (SUM_W'(1) << Q_W) : SUM_W'(tdiv[k].quo));
		end
	end

	always_ff @(posedge clk) begin
		sum_s5 <= sum;
		sat_s5 <= sum >= (SUM_W'(DIV_CONST) << STAT_W);
		err_s5 <= tdiv[0].tag.err;
	end

	assign scl = sum_s5[Q_W-1:RCP_PRE];

	always_ff @(posedge clk) begin
		pp_ll_s6 <= (2*HALF_W)'(scl[HALF_W-1:0]) * (2*HALF_W)'(RCP_M[HALF_W-1:0]);
		pp_lh_s6 <= (2*HALF_W)'(scl[HALF_W-1:0]) * (2*HALF_W)'(RCP_M[RCP_W-1:HALF_W]);
		pp_hl_s6 <= (2*HALF_W)'(scl[SCL_W-1:HALF_W]) * (2*HALF_W)'(RCP_M[HALF_W-1:0]);
		pp_hh_s6 <= (2*HALF_W)'(scl[SCL_W-1:HALF_W]) * (2*HALF_W)'(RCP_M[RCP_W-1:HALF_W]);
		sat_s6   <= sat_s5;
		err_s6   <= err_s5;
	end

	assign prod = (PRD_W'(pp_hh_s6) << (2*HALF_W))
		+ ((PRD_W'(pp_lh_s6) + PRD_W'(pp_hl_s6)) << HALF_W) + PRD_W'(pp_ll_s6);

	always_ff @(posedge clk) begin
		res_q.statistic       <= sat_s6 ? '1 : prod[RCP_SH+STAT_W-1:RCP_SH];
		res_q.integrity_error <= err_s6;
	end

	assign done   = done_q;
	assign result = res_q;

endmodule
